@@ design/prc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg: shared definitions for polygon region containment
// Field widths, default sizes, operation codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int MAX_REGIONS_DEF  = 16;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;

    localparam int OP_W     = 1;
    localparam int REGION_W = 4;
    localparam int VIDX_W   = 6;
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 5;

    // The input fields can only address this many rings and vertices.
    localparam int REGION_SPAN = 2 ** REGION_W;
    localparam int VERTEX_SPAN = 2 ** VIDX_W;

    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic load_point;
        logic ring_start;
        logic rd_en;
        logic rd_first;
    } prc_cmd_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } prc_status_t;

endpackage

@@ design/prc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prc_ram #(
    parameter int WIDTH = 2 * prc_pkg::COORD_BITS_DEF,
    parameter int DEPTH = prc_pkg::MAX_REGIONS_DEF * prc_pkg::MAX_VERTICES_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/prc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_datapath: vertex storage and edge crossing pipeline
// Holds the vertex memory, the ring lengths and the query point, and runs
// one ring edge per cycle through a difference, multiply and compare pipe
// that toggles the crossing parity of the current ring.
// ----------------------------------------------------------------------------
module prc_datapath #(
    parameter int MAX_REGIONS  = prc_pkg::MAX_REGIONS_DEF,
    parameter int MAX_VERTICES = prc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = prc_pkg::COORD_BITS_DEF,
    localparam int NUM_RINGS = (MAX_REGIONS < prc_pkg::REGION_SPAN) ?
                               MAX_REGIONS : prc_pkg::REGION_SPAN,
    localparam int NUM_VERTS = (MAX_VERTICES < prc_pkg::VERTEX_SPAN) ?
                               MAX_VERTICES : prc_pkg::VERTEX_SPAN,
    localparam int RIDX_W    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1,
    localparam int VI_W      = $clog2(NUM_VERTS),
    localparam int LEN_W     = $clog2(NUM_VERTS + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  prc_pkg::prc_cmd_t              cmd,
    output prc_pkg::prc_status_t           status,
    input  logic [RIDX_W-1:0]              rd_ring,
    input  logic [VI_W-1:0]                rd_vtx,
    output logic [LEN_W-1:0]               ring_len,
    input  logic [prc_pkg::REGION_W-1:0]   s_region,
    input  logic [prc_pkg::VIDX_W-1:0]     s_vertex_index,
    input  logic                           s_vertex_last,
    input  logic signed [prc_pkg::COORD_W-1:0] s_lon,
    input  logic signed [prc_pkg::COORD_W-1:0] s_lat
);

    localparam int DEPTH = NUM_RINGS * NUM_VERTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 2 * COORD_BITS;
    localparam int D_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * D_W;

    // Ring lengths and query point.
    logic [LEN_W-1:0]             ring_len_reg [NUM_RINGS];
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;

    // Write decode.
    logic          region_ok;
    logic          vidx_ok;
    logic          wr_ok;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [DW-1:0] ram_rdata;

    // Stage 1: vertex out of memory.
    logic                         v1_valid_reg;
    logic                         v1_first_reg;
    logic signed [COORD_BITS-1:0] cur_lon;
    logic signed [COORD_BITS-1:0] cur_lat;
    logic signed [COORD_BITS-1:0] prev_lon_reg;
    logic signed [COORD_BITS-1:0] prev_lat_reg;
    logic                         straddle;

    // Stage 2: differences.
    logic                  e_valid_reg;
    logic signed [D_W-1:0] dxp_reg;
    logic signed [D_W-1:0] dy_reg;
    logic signed [D_W-1:0] dxj_reg;
    logic signed [D_W-1:0] dyp_reg;

    // Stage 3: products.
    logic                  p_valid_reg;
    logic                  dy_pos_reg;
    logic signed [P_W-1:0] pa_reg;
    logic signed [P_W-1:0] pb_reg;
    logic signed [P_W-1:0] pa_c;
    logic signed [P_W-1:0] pb_c;
    logic                  cross_hit;

    logic parity_reg;

    assign region_ok = ({1'b0, s_region} < (prc_pkg::REGION_W + 1)'(NUM_RINGS));
    assign vidx_ok   = ({1'b0, s_vertex_index} < (prc_pkg::VIDX_W + 1)'(NUM_VERTS));
    assign wr_ok     = cmd.wr_en && region_ok && vidx_ok;

    assign waddr = AW'(RIDX_W'(s_region)) * AW'(NUM_VERTS) + AW'(VI_W'(s_vertex_index));
    assign raddr = AW'(rd_ring) * AW'(NUM_VERTS) + AW'(rd_vtx);

    prc_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_vertex_ram (
        .aclk (aclk),
        .we   (wr_ok),
        .waddr(waddr),
        .wdata({s_lon[COORD_BITS-1:0], s_lat[COORD_BITS-1:0]}),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    assign ring_len = ring_len_reg[rd_ring];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_RINGS; r++) begin
                ring_len_reg[r] <= '0;
            end
        end else if (wr_ok && s_vertex_last) begin
            ring_len_reg[RIDX_W'(s_region)] <=
                LEN_W'({1'b0, s_vertex_index} + (prc_pkg::VIDX_W + 1)'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            px_reg <= s_lon[COORD_BITS-1:0];
            py_reg <= s_lat[COORD_BITS-1:0];
        end
    end

    assign cur_lon  = ram_rdata[DW-1:COORD_BITS];
    assign cur_lat  = ram_rdata[COORD_BITS-1:0];
    assign straddle = (cur_lat > py_reg) != (prev_lat_reg > py_reg);

    // The current vertex is the edge's start point; the previous beat is its end.
    always_ff @(posedge aclk) begin
        if (v1_valid_reg) begin
            prev_lon_reg <= cur_lon;
            prev_lat_reg <= cur_lat;
        end
        dxp_reg <= {px_reg[COORD_BITS-1], px_reg} - {cur_lon[COORD_BITS-1], cur_lon};
        dy_reg  <= {prev_lat_reg[COORD_BITS-1], prev_lat_reg}
                   - {cur_lat[COORD_BITS-1], cur_lat};
        dxj_reg <= {prev_lon_reg[COORD_BITS-1], prev_lon_reg}
                   - {cur_lon[COORD_BITS-1], cur_lon};
        dyp_reg <= {py_reg[COORD_BITS-1], py_reg} - {cur_lat[COORD_BITS-1], cur_lat};
    end

    assign pa_c = dxp_reg * dy_reg;
    assign pb_c = dxj_reg * dyp_reg;

    always_ff @(posedge aclk) begin
        pa_reg     <= pa_c;
        pb_reg     <= pb_c;
        dy_pos_reg <= !dy_reg[D_W-1];
    end

    // Multiplying through by the latitude span flips the comparison when it is negative.
    assign cross_hit = dy_pos_reg ? (pa_reg < pb_reg) : (pb_reg < pa_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
            v1_first_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            parity_reg   <= 1'b0;
        end else begin
            v1_valid_reg <= cmd.rd_en;
            v1_first_reg <= cmd.rd_first;
            e_valid_reg  <= v1_valid_reg && !v1_first_reg && straddle;
            p_valid_reg  <= e_valid_reg;
            if (cmd.ring_start) begin
                parity_reg <= 1'b0;
            end else if (p_valid_reg && cross_hit) begin
                parity_reg <= !parity_reg;
            end
        end
    end

    assign status.busy = v1_valid_reg || e_valid_reg || p_valid_reg;
    assign status.hit  = parity_reg;

endmodule

@@ design/prc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_ctrl: query sequencer
// Accepts input beats, holds the ring count register, walks the rings and
// their vertices for a query, and owns the result register.
// ----------------------------------------------------------------------------
module prc_ctrl #(
    parameter int MAX_REGIONS  = prc_pkg::MAX_REGIONS_DEF,
    parameter int MAX_VERTICES = prc_pkg::MAX_VERTICES_DEF,
    localparam int NUM_RINGS = (MAX_REGIONS < prc_pkg::REGION_SPAN) ?
                               MAX_REGIONS : prc_pkg::REGION_SPAN,
    localparam int NUM_VERTS = (MAX_VERTICES < prc_pkg::VERTEX_SPAN) ?
                               MAX_VERTICES : prc_pkg::VERTEX_SPAN,
    localparam int RIDX_W    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1,
    localparam int VI_W      = $clog2(NUM_VERTS),
    localparam int LEN_W     = $clog2(NUM_VERTS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prc_pkg::OP_W-1:0]      s_operation,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prc_pkg::CFG_W-1:0]     cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_inside_res,
    output logic [prc_pkg::REGION_W-1:0]  m_region_index,
    output prc_pkg::prc_cmd_t             cmd,
    input  prc_pkg::prc_status_t          status,
    input  logic [LEN_W-1:0]              ring_len,
    output logic [RIDX_W-1:0]             rd_ring,
    output logic [VI_W-1:0]               rd_vtx
);

    localparam int RC_W = $clog2(NUM_RINGS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RING   = 5'b00010,
        S_WALK   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [RC_W-1:0]              ring_cnt_reg, ring_cnt_next;
    logic [LEN_W-1:0]             v_cnt_reg, v_cnt_next;
    logic                         found_reg, found_next;
    logic [prc_pkg::CFG_W-1:0]    regions_in_use_reg;
    logic                         m_valid_reg;
    logic                         m_inside_reg;
    logic [prc_pkg::REGION_W-1:0] m_region_reg;
    logic [RC_W-1:0]              count;
    logic [LEN_W-1:0]             len_last;
    logic                         out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regions_in_use_reg <= '0;
        end else if (cfg_valid) begin
            regions_in_use_reg <= cfg_data;
        end
    end

    // Rings past the last addressable one can never hold a vertex.
    assign count = (regions_in_use_reg > prc_pkg::CFG_W'(NUM_RINGS)) ?
                   RC_W'(NUM_RINGS) : RC_W'(regions_in_use_reg);
    assign len_last = ring_len - LEN_W'(1);

    assign rd_ring = RIDX_W'(ring_cnt_reg);
    assign rd_vtx  = (state_reg == S_WALK) ? VI_W'(v_cnt_reg) : VI_W'(len_last);

    always_comb begin
        state_next    = state_reg;
        ring_cnt_next = ring_cnt_reg;
        v_cnt_next    = v_cnt_reg;
        found_next    = found_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == prc_pkg::OP_QUERY) begin
                        cmd.load_point = 1'b1;
                        ring_cnt_next  = '0;
                        found_next     = 1'b0;
                        state_next     = S_RING;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_RING: begin
                if (ring_cnt_reg == count) begin
                    state_next = S_RESULT;
                end else if (ring_len == '0) begin
                    ring_cnt_next = ring_cnt_reg + RC_W'(1);
                end else begin
                    // The last vertex is read first so that the closing edge comes out first.
                    cmd.ring_start = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.rd_first   = 1'b1;
                    v_cnt_next     = '0;
                    state_next     = S_WALK;
                end
            end
            S_WALK: begin
                cmd.rd_en = 1'b1;
                if (v_cnt_reg == len_last) begin
                    state_next = S_DRAIN;
                end else begin
                    v_cnt_next = v_cnt_reg + LEN_W'(1);
                end
            end
            S_DRAIN: begin
                if (!status.busy) begin
                    if (status.hit) begin
                        found_next = 1'b1;
                        state_next = S_RESULT;
                    end else begin
                        ring_cnt_next = ring_cnt_reg + RC_W'(1);
                        state_next    = S_RING;
                    end
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ring_cnt_reg <= '0;
            v_cnt_reg    <= '0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ring_cnt_reg <= ring_cnt_next;
            v_cnt_reg    <= v_cnt_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_inside_reg <= found_reg;
            m_region_reg <= found_reg ? prc_pkg::REGION_W'(ring_cnt_reg) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_inside_res   = m_inside_reg;
    assign m_region_index = m_region_reg;

endmodule

@@ design/polygon_region_containment.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_region_containment: point-in-polygon test over stored rings
// Stores polygon rings vertex by vertex and answers point queries with an
// exact odd-crossing ray cast toward increasing longitude.
// ----------------------------------------------------------------------------
// A write beat stores one vertex and produces no result; a vertex with the
// last flag set fixes the length of its ring. A query beat tests rings 0 up
// to regions_in_use - 1, capped at the last ring, in order and returns one
// result beat naming the first ring that contains the point. The vertex
// memory has one read port and delivers one vertex per cycle; the walk stops
// at the first containing ring. A new beat is taken once the query is done,
// while its result may still wait on m_ready.
// The vertex memory needs no clearing after reset; reading a vertex that was
// never written gives an undefined answer.
module polygon_region_containment #(
    parameter int MAX_REGIONS  = prc_pkg::MAX_REGIONS_DEF,
    parameter int MAX_VERTICES = prc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = prc_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [prc_pkg::OP_W-1:0]           s_operation,
    input  logic [prc_pkg::REGION_W-1:0]       s_region,
    input  logic [prc_pkg::VIDX_W-1:0]         s_vertex_index,
    input  logic                               s_vertex_last,
    input  logic signed [prc_pkg::COORD_W-1:0] s_lon,
    input  logic signed [prc_pkg::COORD_W-1:0] s_lat,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prc_pkg::CFG_W-1:0]          cfg_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_inside_res,
    output logic [prc_pkg::REGION_W-1:0]       m_region_index
);

    localparam int NUM_RINGS = (MAX_REGIONS < prc_pkg::REGION_SPAN) ?
                               MAX_REGIONS : prc_pkg::REGION_SPAN;
    localparam int NUM_VERTS = (MAX_VERTICES < prc_pkg::VERTEX_SPAN) ?
                               MAX_VERTICES : prc_pkg::VERTEX_SPAN;
    localparam int RIDX_W    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int VI_W      = $clog2(NUM_VERTS);
    localparam int LEN_W     = $clog2(NUM_VERTS + 1);

    prc_pkg::prc_cmd_t    cmd;
    prc_pkg::prc_status_t status;
    logic [LEN_W-1:0]     ring_len;
    logic [RIDX_W-1:0]    rd_ring;
    logic [VI_W-1:0]      rd_vtx;

    prc_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_region_index(m_region_index),
        .cmd           (cmd),
        .status        (status),
        .ring_len      (ring_len),
        .rd_ring       (rd_ring),
        .rd_vtx        (rd_vtx)
    );

    prc_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .rd_ring       (rd_ring),
        .rd_vtx        (rd_vtx),
        .ring_len      (ring_len),
        .s_region      (s_region),
        .s_vertex_index(s_vertex_index),
        .s_vertex_last (s_vertex_last),
        .s_lon         (s_lon),
        .s_lat         (s_lat)
    );

    // A query holds off the input until its walk is done.
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == prc_pkg::OP_QUERY) |=> !s_ready)
        else $error("input accepted right after a query beat");

    // A write completes in its own cycle.
    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == prc_pkg::OP_WRITE) |=> s_ready)
        else $error("input stalled after a write beat");

    // A miss reports ring zero.
    a_miss_region: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_inside_res) |-> (m_region_index == '0))
        else $error("nonzero region index on a miss");

    // The walk never issues reads while the input side is open.
    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.rd_en)
        else $error("vertex read while idle");

endmodule
